// ===== hw/rtl/bdpc_pkg.sv =====
// Shared types, codes and trigger helpers for the button debounce and press classifier.
`timescale 1ns / 1ps

package bdpc_pkg;

   localparam int COUNT_BITS_DEFAULT = 16;
   localparam int CSR_INDEX_BITS     = 3;
   localparam int CSR_DATA_BITS      = 16;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RUN_ENABLE   = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ACTIVE_LEVEL = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_EDGE_MODE    = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEBOUNCE_ON  = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEB_TICKS    = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SHORT_LIMIT  = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LONG_LIMIT   = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_POLL_PERIOD  = 3'd7;

   // Press classification codes.
   localparam logic [1:0] PRESS_NONE    = 2'd0;
   localparam logic [1:0] PRESS_DEFAULT = 2'd1;
   localparam logic [1:0] PRESS_LONG    = 2'd2;

   // Active level codes.
   localparam logic [1:0] ACTIVE_LOW  = 2'd0;
   localparam logic [1:0] ACTIVE_HIGH = 2'd1;
   localparam logic [1:0] ACTIVE_BOTH = 2'd2;

   typedef enum logic [1:0] {
      TRIG_NONE,
      TRIG_RISE,
      TRIG_FALL,
      TRIG_BOTH
   } trig_type;

   typedef struct packed {
      logic        run_enable;
      logic [1:0]  active_level;
      logic        edge_mode;
      logic        debounce_on;
      logic [15:0] debounce_ticks;
      logic [15:0] short_press_limit;
      logic [15:0] long_press_limit;
      logic [9:0]  poll_period;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      run_enable:        1'b0,
      active_level:      ACTIVE_LOW,
      edge_mode:         1'b0,
      debounce_on:       1'b1,
      debounce_ticks:    16'd20,
      short_press_limit: 16'd1000,
      long_press_limit:  16'd3000,
      poll_period:       10'd10
   };

   typedef struct packed {
      logic step;
      logic pin_level;
      logic restart;
   } ctrl_type;

   typedef struct packed {
      logic       event_res;
      logic [1:0] press_class;
      logic       is_pressed;
   } result_type;

   function automatic trig_type press_trig(input logic [1:0] level);
      trig_type t;
      case (level)
         ACTIVE_LOW:  t = TRIG_FALL;
         ACTIVE_HIGH: t = TRIG_RISE;
         ACTIVE_BOTH: t = TRIG_BOTH;
         default:     t = TRIG_NONE;
      endcase
      return t;
   endfunction

   function automatic trig_type release_trig(input logic [1:0] level);
      trig_type t;
      case (level)
         ACTIVE_LOW:  t = TRIG_RISE;
         ACTIVE_HIGH: t = TRIG_FALL;
         ACTIVE_BOTH: t = TRIG_BOTH;
         default:     t = TRIG_NONE;
      endcase
      return t;
   endfunction

   function automatic logic level_ok(input trig_type t, input logic pin);
      logic ok;
      case (t)
         TRIG_RISE: ok = pin;
         TRIG_FALL: ok = ~pin;
         TRIG_BOTH: ok = 1'b1;
         default:   ok = 1'b0;
      endcase
      return ok;
   endfunction

   function automatic logic edge_ok(input trig_type t, input logic prev, input logic pin);
      logic ok;
      case (t)
         TRIG_RISE: ok = ~prev & pin;
         TRIG_FALL: ok = prev & ~pin;
         TRIG_BOTH: ok = prev ^ pin;
         default:   ok = 1'b0;
      endcase
      return ok;
   endfunction

endpackage

// ===== hw/rtl/bdpc_req_if.sv =====
// Request channel interface: one pin sample per transaction.
`timescale 1ns / 1ps

interface bdpc_req_if;
   logic valid;
   logic ready;
   logic pin_level;

   modport source (output valid, output pin_level, input ready);
   modport sink   (input valid, input pin_level, output ready);
endinterface

// ===== hw/rtl/bdpc_rsp_if.sv =====
// Response channel interface: one classification result per transaction.
`timescale 1ns / 1ps

interface bdpc_rsp_if;
   logic       valid;
   logic       ready;
   logic       event_res;
   logic [1:0] press_class;
   logic       is_pressed;

   modport source (output valid, output event_res, output press_class, output is_pressed,
                   input ready);
   modport sink   (input valid, input event_res, input press_class, input is_pressed,
                   output ready);
endinterface

// ===== hw/rtl/bdpc_core.sv =====
// Button state machine, debounce countdown, poll timer and press duration classifier.
`timescale 1ns / 1ps

module bdpc_core #(
   parameter int COUNT_BITS = bdpc_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  bdpc_pkg::ctrl_type   ctrl,
   input  bdpc_pkg::cfg_type    cfg,
   output bdpc_pkg::result_type result
);

   localparam int CMP_BITS = (COUNT_BITS > 16) ? COUNT_BITS : 16;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DEB_PRESS,
      ST_PRESSED,
      ST_DEB_RELEASE
   } state_type;

   state_type             state_ff, state_in;
   logic [15:0]           deb_ff, deb_in;
   logic [COUNT_BITS-1:0] press_ff, press_in;
   logic [9:0]            poll_ff, poll_in;
   logic                  last_ff;
   logic [1:0]            held_ff, held_in;

   logic [COUNT_BITS-1:0] press_inc;
   logic [1:0]            class_code;
   bdpc_pkg::trig_type    trig;
   logic                  det;
   logic                  ok;
   logic                  ev;
   logic [15:0]           deb_dec;
   logic [9:0]            poll_next;
   logic [9:0]            period;

   // Duration counter saturates at all ones.
   assign press_inc = (press_ff != '1) ? press_ff + 1'b1 : press_ff;

   always_comb begin
      if (CMP_BITS'(press_inc) < CMP_BITS'(cfg.short_press_limit)) begin
         class_code = bdpc_pkg::PRESS_DEFAULT;
      end else if (CMP_BITS'(press_inc) < CMP_BITS'(cfg.long_press_limit)) begin
         class_code = bdpc_pkg::PRESS_LONG;
      end else begin
         class_code = bdpc_pkg::PRESS_NONE;
      end
   end

   assign trig = (state_ff == ST_PRESSED || state_ff == ST_DEB_RELEASE)
                 ? bdpc_pkg::release_trig(cfg.active_level)
                 : bdpc_pkg::press_trig(cfg.active_level);

   assign deb_dec   = (deb_ff != 16'd0) ? deb_ff - 16'd1 : 16'd0;
   assign poll_next = poll_ff + 10'd1;
   assign period    = (cfg.poll_period == 10'd0) ? 10'd1 : cfg.poll_period;

   always_comb begin
      state_in = state_ff;
      deb_in   = deb_ff;
      press_in = press_ff;
      poll_in  = poll_ff;
      held_in  = held_ff;
      ev       = 1'b0;
      det      = 1'b0;
      ok       = 1'b0;
      if (cfg.run_enable) begin
         press_in = press_inc;
         if (state_ff == ST_DEB_PRESS || state_ff == ST_DEB_RELEASE) begin
            // A running countdown finishes even if debounce was switched off.
            deb_in = deb_dec;
            if (deb_dec == 16'd0) begin
               ok = bdpc_pkg::level_ok(trig, ctrl.pin_level);
               if (ok && state_ff == ST_DEB_PRESS) begin
                  state_in = ST_PRESSED;
                  press_in = '0;
               end else begin
                  state_in = ST_IDLE;
                  if (ok) begin
                     held_in = class_code;
                     ev      = 1'b1;
                  end
               end
            end
         end else begin
            if (cfg.edge_mode) begin
               det = bdpc_pkg::edge_ok(trig, last_ff, ctrl.pin_level);
               if (det && state_ff == ST_IDLE) begin
                  held_in  = bdpc_pkg::PRESS_NONE;
                  press_in = '0;
               end
            end else if (poll_next >= period) begin
               poll_in = 10'd0;
               det     = bdpc_pkg::level_ok(trig, ctrl.pin_level);
            end else begin
               poll_in = poll_next;
            end
            if (det) begin
               if (cfg.debounce_on) begin
                  state_in = (state_ff == ST_IDLE) ? ST_DEB_PRESS : ST_DEB_RELEASE;
                  deb_in   = (cfg.debounce_ticks == 16'd0) ? 16'd1 : cfg.debounce_ticks;
               end else if (state_ff == ST_IDLE) begin
                  state_in = ST_PRESSED;
                  press_in = '0;
                  held_in  = bdpc_pkg::PRESS_DEFAULT;
                  ev       = 1'b1;
               end else begin
                  state_in = ST_IDLE;
                  held_in  = class_code;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         deb_ff   <= '0;
         press_ff <= '0;
         poll_ff  <= '0;
         last_ff  <= 1'b0;
         held_ff  <= bdpc_pkg::PRESS_NONE;
      end else if (ctrl.restart) begin
         state_ff <= ST_IDLE;
         deb_ff   <= '0;
         poll_ff  <= '0;
      end else if (ctrl.step) begin
         state_ff <= state_in;
         deb_ff   <= deb_in;
         press_ff <= press_in;
         poll_ff  <= poll_in;
         last_ff  <= ctrl.pin_level;
         held_ff  <= held_in;
      end
   end

   assign result.event_res   = ev;
   assign result.press_class = held_in;
   assign result.is_pressed  = (state_in == ST_PRESSED || state_in == ST_DEB_RELEASE);

endmodule

// ===== hw/rtl/button_debounce_press_classifier.sv =====
// Top level of the button debounce and press classifier.
`timescale 1ns / 1ps

// Each request transaction carries one millisecond pin sample and yields exactly one
// response transaction with the event flag, the latest press classification and the
// pressed status. A sample is accepted in every cycle unless both entries are full:
// the state update is a single pass through the button state machine and its
// counters, and the result is registered in the output register, or, if that is
// stalled, in a second skid entry behind it, which keeps req_bus.ready independent
// of rsp_bus.ready. Configuration writes take effect on the next clock edge and
// should be issued while no response is outstanding; writing run_enable returns the
// button to idle. COUNT_BITS sets the width of the saturating press duration counter.

module button_debounce_press_classifier #(
   parameter int COUNT_BITS = bdpc_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   bdpc_req_if.sink                            req_bus,
   bdpc_rsp_if.source                          rsp_bus,
   input  logic                                csr_write,
   input  logic [bdpc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [bdpc_pkg::CSR_DATA_BITS-1:0]  csr_data
);

   bdpc_pkg::cfg_type    cfg_ff;
   bdpc_pkg::ctrl_type   ctrl;
   bdpc_pkg::result_type result;
   bdpc_pkg::result_type out_ff;
   bdpc_pkg::result_type skid_ff;
   logic                 out_valid_ff;
   logic                 skid_valid_ff;
   logic                 accept;
   logic                 out_free;

   assign req_bus.ready = ~skid_valid_ff;
   assign accept        = req_bus.valid & req_bus.ready;
   assign out_free      = ~out_valid_ff | rsp_bus.ready;

   assign ctrl.step      = accept;
   assign ctrl.pin_level = req_bus.pin_level;
   assign ctrl.restart   = csr_write && (csr_index == bdpc_pkg::CSR_RUN_ENABLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= bdpc_pkg::CFG_RESET;
      end else if (csr_write) begin
         case (csr_index)
            bdpc_pkg::CSR_RUN_ENABLE:   cfg_ff.run_enable        <= csr_data[0];
            bdpc_pkg::CSR_ACTIVE_LEVEL: cfg_ff.active_level      <= csr_data[1:0];
            bdpc_pkg::CSR_EDGE_MODE:    cfg_ff.edge_mode         <= csr_data[0];
            bdpc_pkg::CSR_DEBOUNCE_ON:  cfg_ff.debounce_on       <= csr_data[0];
            bdpc_pkg::CSR_DEB_TICKS:    cfg_ff.debounce_ticks    <= csr_data;
            bdpc_pkg::CSR_SHORT_LIMIT:  cfg_ff.short_press_limit <= csr_data;
            bdpc_pkg::CSR_LONG_LIMIT:   cfg_ff.long_press_limit  <= csr_data;
            bdpc_pkg::CSR_POLL_PERIOD:  cfg_ff.poll_period       <= csr_data[9:0];
            default: ;
         endcase
      end
   end

   bdpc_core #(
      .COUNT_BITS(COUNT_BITS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .cfg    (cfg_ff),
      .result (result)
   );

   // The skid entry is only filled while the output register is stalled, and it
   // drains into the output register before any new transaction is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_valid_ff) begin
            out_ff        <= skid_ff;
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_ff       <= result;
            out_valid_ff <= accept;
         end
      end else if (accept) begin
         skid_ff       <= result;
         skid_valid_ff <= 1'b1;
      end
   end

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.event_res   = out_ff.event_res;
   assign rsp_bus.press_class = out_ff.press_class;
   assign rsp_bus.is_pressed  = out_ff.is_pressed;

endmodule

// ===== hw/rtl/bdpc_checker.sv =====
// Port-level checks for the button debounce and press classifier, bound to the top level.
`timescale 1ns / 1ps

module bdpc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_event_res,
   input logic [1:0] rsp_press_class,
   input logic       rsp_is_pressed
);

   // Nothing may come out in the cycle after a reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // Backpressure on the request side only happens with a result waiting.
   a_ready_needs_pending: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("request stalled with no response pending");

   // The only event seen while pressed is the undebounced press itself.
   a_press_event_type: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_event_res && rsp_is_pressed) |->
         (rsp_press_class == bdpc_pkg::PRESS_DEFAULT))
      else $error("press event with wrong press class");

   a_type_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_press_class <= bdpc_pkg::PRESS_LONG))
      else $error("unused press class code");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_event_res) && $stable(rsp_press_class)
          && $stable(rsp_is_pressed)))
      else $error("stalled response changed");

endmodule

bind button_debounce_press_classifier bdpc_checker u_bdpc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_event_res   (rsp_bus.event_res),
   .rsp_press_class (rsp_bus.press_class),
   .rsp_is_pressed  (rsp_bus.is_pressed)
);
